// ----- hw/rtl/srle_pkg.sv -----
// shared types and constants for the raster rle rgb unpacker
package srle_pkg;

    localparam logic [7:0] ESC_BYTE    = 8'h80;
    // count byte after an escape that stands for a literal escape byte
    localparam logic [7:0] ESC_LITERAL = 8'h00;

    // result queue sizing
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // register indexes of the configuration port
    localparam logic CFG_ENCODED_MODE = 1'b0;
    localparam logic CFG_ROW_WIDTH    = 1'b1;

    // 171 / 512 approximates 1/3 exactly enough for values up to 256
    localparam logic [7:0] RECIP3 = 8'd171;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       new_image;
    } t_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [6:0] repeat_res;
        logic       last;
    } t_result;

endpackage

// ----- hw/rtl/sun_raster_rle_rgb_unpack.sv -----
// raster byte stream to rgb pixel unpacker, run-length or raw triplets
//
// usage
//   input channel: one data byte per transfer on i_in_data, with i_in_valid
//   and o_in_stall. new_image in the item clears the parse state first.
//   output channel: one pixel result per transfer on o_out_data, with
//   o_out_valid and i_out_stall. a run may produce a mixed pixel plus one
//   uniform pixel carrying a repeat count; last marks the final result of
//   the byte that caused it.
//   configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 encoded mode, 1 row width); write only while the block is idle.
// timing
//   each accepted byte is decoded in the same cycle and its results are
//   registered into a four-entry result queue, which offers them in order.
//   one byte per cycle is taken as long as the queue has room for two
//   results, so o_in_stall rises whenever fewer than two entries are free,
//   whether from receiver stalls or from runs that add two results per byte.
// reset
//   synchronous active-low reset empties the queue, clears parse state and
//   sets encoded mode with a row width of one.
module sun_raster_rle_rgb_unpack (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // byte input channel
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  srle_pkg::t_item i_in_data,
    // pixel output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output srle_pkg::t_result o_out_data,
    // configuration write port
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [15:0]     i_cfg_data
);

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_COUNT  = 2'd1,
        PH_VALUE  = 2'd2,
        PH_PAD    = 2'd3
    } t_phase;

    // configuration registers
    logic        r_encoded_mode;
    logic [15:0] r_row_width;

    // parse state
    t_phase      r_phase,   n_phase;
    logic [7:0]  r_run_len, n_run_len;
    logic [1:0]  r_pcount,  n_pcount;
    logic [7:0]  r_pb0,     n_pb0;
    logic [7:0]  r_pb1,     n_pb1;
    logic [15:0] r_col,     n_col;

    // result queue
    srle_pkg::t_result                   r_fifo [srle_pkg::FIFO_DEPTH];
    logic [srle_pkg::FIFO_AW-1:0]        r_head, r_tail;
    logic [srle_pkg::FIFO_CW-1:0]        r_count, n_count;

    // state seen by this byte, after an optional new image clear
    t_phase      e_phase;
    logic [7:0]  e_run_len;
    logic [1:0]  e_pcount;
    logic [7:0]  e_pb0, e_pb1;
    logic [15:0] e_col;

    logic        in_xfer, out_xfer;
    logic [7:0]  c;
    logic        do_push, do_run, raw_push;
    logic [7:0]  push_val;
    logic [15:0] col_inc;
    logic [1:0]  push_cnt;
    srle_pkg::t_result res_a, res_b;

    // run arithmetic
    logic [8:0]  total, total_adj;
    logic [16:0] prod;
    logic [6:0]  run_q;
    logic [8:0]  three_q;
    logic [1:0]  run_r;
    logic        mixed;

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = o_out_valid && !i_out_stall;
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_fifo[r_head];
    // room for the worst case of two results per byte
    assign o_in_stall  = (r_count > srle_pkg::FIFO_CW'(srle_pkg::FIFO_DEPTH - 2));
    assign c           = i_in_data.in_byte;

    always_comb begin
        // apply new image clear before the byte is used
        if (i_in_data.new_image) begin
            e_phase   = PH_NORMAL;
            e_run_len = '0;
            e_pcount  = '0;
            e_pb0     = '0;
            e_pb1     = '0;
            e_col     = '0;
        end else begin
            e_phase   = r_phase;
            e_run_len = r_run_len;
            e_pcount  = r_pcount;
            e_pb0     = r_pb0;
            e_pb1     = r_pb1;
            e_col     = r_col;
        end

        n_phase   = e_phase;
        n_run_len = e_run_len;
        n_pcount  = e_pcount;
        n_pb0     = e_pb0;
        n_pb1     = e_pb1;
        n_col     = e_col;

        do_push   = 1'b0;
        do_run    = 1'b0;
        raw_push  = 1'b0;
        push_val  = c;
        push_cnt  = '0;
        res_a     = '0;
        res_b     = '0;
        col_inc   = e_col + 16'd1;

        // byte classification
        if (r_encoded_mode) begin
            case (e_phase)
                PH_COUNT: begin
                    if (c == srle_pkg::ESC_LITERAL) begin
                        // escaped literal
                        do_push  = 1'b1;
                        push_val = srle_pkg::ESC_BYTE;
                        n_phase  = PH_NORMAL;
                    end else begin
                        n_run_len = c;
                        n_phase   = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    do_run  = 1'b1;
                    n_phase = PH_NORMAL;
                end
                default: begin
                    if (c == srle_pkg::ESC_BYTE) begin
                        n_phase = PH_COUNT;
                    end else begin
                        n_phase = PH_NORMAL;
                        do_push = 1'b1;
                    end
                end
            endcase
        end else begin
            n_phase = PH_NORMAL;
            if (e_phase != PH_PAD) begin
                do_push  = 1'b1;
                raw_push = 1'b1;
            end
        end

        // single byte into the triplet
        if (do_push) begin
            if (e_pcount >= 2'd2) begin
                res_a.red        = push_val;
                res_a.green      = e_pb1;
                res_a.blue       = e_pb0;
                res_a.repeat_res = 7'd1;
                push_cnt         = 2'd1;
                n_pcount         = '0;
                if (raw_push) begin
                    if (col_inc >= r_row_width) begin
                        n_col = '0;
                        if (r_row_width[0]) begin
                            n_phase = PH_PAD;
                        end
                    end else begin
                        n_col = col_inc;
                    end
                end
            end else begin
                if (!e_pcount[0]) begin
                    n_pb0 = push_val;
                end else begin
                    n_pb1 = push_val;
                end
                n_pcount = e_pcount + 2'd1;
            end
        end

        // run of run_len + 1 copies of c
        total     = {1'b0, e_run_len} + 9'd1;
        mixed     = (e_pcount != 2'd0);
        total_adj = total;
        if (e_pcount == 2'd1) begin
            total_adj = total - 9'd2;
        end else if (e_pcount >= 2'd2) begin
            total_adj = total - 9'd1;
        end
        prod    = total_adj * srle_pkg::RECIP3;
        run_q   = prod[15:9];
        three_q = {1'b0, run_q, 1'b0} + {2'b00, run_q};
        run_r   = 2'(total_adj - three_q);

        if (do_run) begin
            if (mixed) begin
                res_a.red        = c;
                res_a.green      = (e_pcount == 2'd1) ? c : e_pb1;
                res_a.blue       = e_pb0;
                res_a.repeat_res = 7'd1;
                push_cnt         = 2'd1;
            end
            if (run_q != '0) begin
                if (mixed) begin
                    res_b.red        = c;
                    res_b.green      = c;
                    res_b.blue       = c;
                    res_b.repeat_res = run_q;
                    push_cnt         = 2'd2;
                end else begin
                    res_a.red        = c;
                    res_a.green      = c;
                    res_a.blue       = c;
                    res_a.repeat_res = run_q;
                    push_cnt         = 2'd1;
                end
            end
            // leftover copies stay pending
            if (run_r != 2'd0) begin
                n_pb0 = c;
            end
            if (run_r == 2'd2) begin
                n_pb1 = c;
            end
            n_pcount = run_r;
        end

        res_a.last = (push_cnt == 2'd1);
        res_b.last = 1'b1;

        n_count = r_count
                + (in_xfer ? srle_pkg::FIFO_CW'(push_cnt) : '0)
                - (out_xfer ? srle_pkg::FIFO_CW'(1) : '0);
    end

    // control and parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_encoded_mode <= 1'b1;
            r_row_width    <= 16'd1;
            r_phase        <= PH_NORMAL;
            r_run_len      <= '0;
            r_pcount       <= '0;
            r_pb0          <= '0;
            r_pb1          <= '0;
            r_col          <= '0;
            r_head         <= '0;
            r_tail         <= '0;
            r_count        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    srle_pkg::CFG_ENCODED_MODE: r_encoded_mode <= i_cfg_data[0];
                    srle_pkg::CFG_ROW_WIDTH:    r_row_width    <= i_cfg_data;
                    default:                    r_row_width    <= r_row_width;
                endcase
            end
            if (in_xfer) begin
                r_phase   <= n_phase;
                r_run_len <= n_run_len;
                r_pcount  <= n_pcount;
                r_pb0     <= n_pb0;
                r_pb1     <= n_pb1;
                r_col     <= n_col;
                r_tail    <= r_tail + srle_pkg::FIFO_AW'(push_cnt);
            end
            if (out_xfer) begin
                r_head <= r_head + srle_pkg::FIFO_AW'(1);
            end
            r_count <= n_count;
        end
    end

    // result queue storage, payload only
    always_ff @(posedge i_clk) begin
        if (in_xfer && push_cnt != 2'd0) begin
            r_fifo[r_tail] <= res_a;
        end
        if (in_xfer && push_cnt == 2'd2) begin
            r_fifo[r_tail + srle_pkg::FIFO_AW'(1)] <= res_b;
        end
    end

`ifndef SYNTH
    // queue never holds more than its depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= srle_pkg::FIFO_CW'(srle_pkg::FIFO_DEPTH))
        else $error("result queue count out of range");

    // a byte is only taken with room for two results
    a_room_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> r_count <= srle_pkg::FIFO_CW'(srle_pkg::FIFO_DEPTH - 2))
        else $error("byte accepted without room for two results");

    // pending byte count stays below a full triplet
    a_pcount_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcount != 2'd3)
        else $error("pending count reached three");

    // two results come only from a run value byte in encoded mode
    a_two_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && push_cnt == 2'd2) |-> (r_encoded_mode && e_phase == PH_VALUE))
        else $error("two results from a byte that is not a run value");

    // a transfer leaves the queue one entry lighter unless a byte refilled it
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && !in_xfer) |=> r_count == $past(r_count) - srle_pkg::FIFO_CW'(1))
        else $error("queue count did not drop after output transfer");
`endif

endmodule

// ----- test/tb_sun_raster_rle_rgb_unpack.sv -----
// testbench for the raster rle rgb unpacker: predicted pixels checked under random stalls
`timescale 1ns / 1ps

module tb_sun_raster_rle_rgb_unpack;

    localparam int unsigned HALF_NS      = 4;
    localparam int unsigned RESET_CYCLES = 12;
    localparam int unsigned RX_HOLD      = 300;
    localparam int unsigned SETTLE       = 8;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned TIMEOUT_NS   = 2_000_000;

    typedef enum logic [1:0] {
        PH_NORMAL,
        PH_COUNT,
        PH_VALUE,
        PH_PAD
    } t_phase;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    srle_pkg::t_item   in_data   = '0;
    logic              in_stall;
    logic              out_valid;
    logic              out_stall = 1'b0;
    srle_pkg::t_result out_data;
    logic              cfg_we    = 1'b0;
    logic              cfg_index = 1'b0;
    logic [15:0]       cfg_data  = '0;

    // predictor copy of registers and decode state
    logic        enc_mode;
    logic [15:0] row_w;
    t_phase      phase;
    logic [7:0]  run_len;
    logic [1:0]  pend_cnt;
    logic [7:0]  pend [2];
    logic [15:0] col_cnt;

    srle_pkg::t_result expected_pixels [$];
    srle_pkg::t_result step_pixels [$];
    int unsigned bad_pixels  = 0;
    int unsigned item_count  = 0;
    int unsigned hold_orders = 0;
    int unsigned hold_served = 0;
    bit          tx_idle_en  = 1'b1;
    bit          rx_idle_en  = 1'b1;

    sun_raster_rle_rgb_unpack u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #HALF_NS clk = 1'b1;
        #HALF_NS clk = 1'b0;
    end

    initial begin : watchdog
        #TIMEOUT_NS;
        $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_decode();
        phase    = PH_NORMAL;
        run_len  = '0;
        pend_cnt = '0;
        pend[0]  = '0;
        pend[1]  = '0;
        col_cnt  = '0;
    endfunction

    function automatic void add_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                      logic [6:0] rep);
        srle_pkg::t_result px;
        px.red        = r;
        px.green      = g;
        px.blue       = b;
        px.repeat_res = rep;
        px.last       = 1'b0;
        step_pixels.push_back(px);
    endfunction

    // third byte of a triplet completes a pixel, blue first
    function automatic void push_triplet(logic [7:0] c);
        if (pend_cnt >= 2'd2) begin
            add_pixel(c, pend[1], pend[0], 7'd1);
            pend_cnt = '0;
        end else begin
            pend[pend_cnt[0]] = c;
            pend_cnt = pend_cnt + 2'd1;
        end
    endfunction

    // n+1 copies of v: mixed pixel first, then one uniform pixel with a count
    function automatic void expand_run(logic [7:0] v);
        int unsigned total;
        int unsigned rem;
        total = int'(run_len) + 1;
        if (pend_cnt == 2'd1) begin
            add_pixel(v, v, pend[0], 7'd1);
            total -= 2;
        end else if (pend_cnt >= 2'd2) begin
            add_pixel(v, pend[1], pend[0], 7'd1);
            total -= 1;
        end
        if (total / 3 > 0)
            add_pixel(v, v, v, 7'(total / 3));
        rem = total % 3;
        for (int unsigned i = 0; i < rem; i++)
            pend[i[0]] = v;
        pend_cnt = 2'(rem);
    endfunction

    function automatic void decode_byte(srle_pkg::t_item it);
        logic [7:0] c;
        c = it.in_byte;
        step_pixels.delete();
        if (it.new_image)
            clear_decode();
        if (enc_mode) begin
            if (phase == PH_COUNT) begin
                if (c == srle_pkg::ESC_LITERAL) begin
                    push_triplet(srle_pkg::ESC_BYTE);
                    phase = PH_NORMAL;
                end else begin
                    run_len = c;
                    phase   = PH_VALUE;
                end
            end else if (phase == PH_VALUE) begin
                expand_run(c);
                phase = PH_NORMAL;
            end else begin
                // pad phase left from raw mode counts as normal here
                phase = (c == srle_pkg::ESC_BYTE) ? PH_COUNT : PH_NORMAL;
                if (c != srle_pkg::ESC_BYTE)
                    push_triplet(c);
            end
        end else begin
            if (phase == PH_PAD) begin
                phase = PH_NORMAL;
            end else begin
                // escape phases left from encoded mode count as normal here
                phase = PH_NORMAL;
                push_triplet(c);
                if (step_pixels.size() > 0) begin
                    col_cnt = col_cnt + 16'd1;
                    if (col_cnt >= row_w) begin
                        col_cnt = '0;
                        if (row_w[0])
                            phase = PH_PAD;
                    end
                end
            end
        end
        if (step_pixels.size() > 0)
            step_pixels[step_pixels.size() - 1].last = 1'b1;
        foreach (step_pixels[i])
            expected_pixels.push_back(step_pixels[i]);
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("t=%0t %s expected %0d actual %0d", $time, name, want, got);
            bad_pixels++;
        end
    endfunction

    always @(posedge clk) begin : pixel_check
        srle_pkg::t_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_pixels.size() == 0) begin
                $display("t=%0t pixel with none pending: expected none actual %h",
                         $time, out_data);
                bad_pixels++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("red", 32'(want.red), 32'(out_data.red));
                check_field("green", 32'(want.green), 32'(out_data.green));
                check_field("blue", 32'(want.blue), 32'(out_data.blue));
                check_field("repeat_res", 32'(want.repeat_res),
                            32'(out_data.repeat_res));
                check_field("last", 32'(want.last), 32'(out_data.last));
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    // random stall bursts, plus a long hold-off whenever one is ordered
    initial begin : rx_stall_drive
        int unsigned hold_left;
        int unsigned burst_left;
        hold_left  = 0;
        burst_left = 0;
        forever begin
            @(posedge clk);
            if (hold_left == 0 && hold_orders != hold_served) begin
                hold_left = RX_HOLD;
                hold_served++;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                out_stall <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(0, 5);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- sender

    task automatic send_byte(input logic [7:0] b, input logic ni);
        srle_pkg::t_item it;
        it.in_byte   = b;
        it.new_image = ni;
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_byte(it);
        item_count++;
    endtask

    task automatic wait_for_results();
        while (expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    // stop offering, let everything drain, give the decoder time to settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        wait_for_results();
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic configure(input logic mode, input logic [15:0] width);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= srle_pkg::CFG_ENCODED_MODE;
        cfg_data  <= {15'd0, mode};
        @(posedge clk);
        cfg_index <= srle_pkg::CFG_ROW_WIDTH;
        cfg_data  <= width;
        @(posedge clk);
        cfg_we   <= 1'b0;
        enc_mode  = mode;
        row_w     = width;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_width();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3:       return 16'hFFFE;
            4:       return 16'd2;
            default: return 16'($urandom_range(1, 9));
        endcase
    endfunction

    // mostly well-formed encoded sequences, some lone bytes and restarts
    task automatic send_encoded_chunk();
        int unsigned sel;
        logic        ni;
        logic [7:0]  b;
        logic [7:0]  cnt;
        sel = $urandom_range(0, 99);
        ni  = ($urandom_range(0, 39) == 0);
        if (sel < 45) begin
            b = 8'($urandom_range(0, 255));
            if (b == srle_pkg::ESC_BYTE)
                b = ~srle_pkg::ESC_BYTE;
            send_byte(b, ni);
        end else if (sel < 55) begin
            send_byte(srle_pkg::ESC_BYTE, ni);
            send_byte(srle_pkg::ESC_LITERAL, 1'b0);
        end else if (sel < 90) begin
            case ($urandom_range(0, 3))
                0:       cnt = 8'hFF;
                1:       cnt = 8'($urandom_range(1, 255));
                default: cnt = 8'($urandom_range(1, 8));
            endcase
            send_byte(srle_pkg::ESC_BYTE, ni);
            send_byte(cnt, 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            b = $urandom_range(0, 1) ? srle_pkg::ESC_BYTE : 8'($urandom_range(0, 255));
            send_byte(b, $urandom_range(0, 3) == 0);
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        // reset settings: encoded, width one
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        // escaped literal, then a run over one pending byte
        send_byte(srle_pkg::ESC_BYTE, 1'b0);
        send_byte(srle_pkg::ESC_LITERAL, 1'b0);
        send_byte(srle_pkg::ESC_BYTE, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'hAA, 1'b0);
        // longest run over two pending bytes
        send_byte(8'h81, 1'b0);
        send_byte(srle_pkg::ESC_BYTE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b0);
        // shortest run, nothing pending, only leftovers
        send_byte(srle_pkg::ESC_BYTE, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h33, 1'b0);
        // escape left open across a switch to raw mode
        send_byte(srle_pkg::ESC_BYTE, 1'b0);
        configure(1'b0, 16'd1);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hEE, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        // pad byte still owed when encoded mode returns
        configure(1'b1, 16'd1);
        send_byte(8'h5A, 1'b0);
        // zero width: no pad ever
        configure(1'b0, 16'd0);
        send_byte(8'h10, 1'b1);
        for (int i = 1; i < 6; i++)
            send_byte(8'(8'h10 * (i + 1)), 1'b0);
    endtask

    task automatic test_random_encoded();
        int unsigned start;
        for (int s = 0; s < 3; s++) begin
            configure(1'b1, (s == 0) ? 16'd0 : (s == 1) ? 16'hFFFF : pick_width());
            start = item_count;
            while (item_count - start < 140)
                send_encoded_chunk();
        end
    endtask

    task automatic test_random_raw();
        logic [15:0] widths [6];
        int unsigned start;
        logic [7:0]  b;
        widths = '{16'd1, 16'd0, 16'hFFFF, 16'd2, 16'd3, 16'd7};
        foreach (widths[w]) begin
            configure(1'b0, widths[w]);
            start = item_count;
            while (item_count - start < 70) begin
                b = ($urandom_range(0, 7) == 0) ? srle_pkg::ESC_BYTE
                                                : 8'($urandom_range(0, 255));
                send_byte(b, $urandom_range(0, 59) == 0);
            end
        end
    endtask

    // mode flips with decode state kept across the switch
    task automatic test_mode_switching();
        int unsigned start;
        for (int r = 0; r < 10; r++) begin
            configure(r[0], pick_width());
            start = item_count;
            while (item_count - start < 30)
                send_encoded_chunk();
        end
    endtask

    // long receiver hold-off while bytes keep coming, so input stall must rise
    task automatic test_output_backpressure();
        int unsigned start;
        configure(1'b1, 16'd1);
        tx_idle_en  = 1'b0;
        hold_orders = hold_orders + 1;
        start = item_count;
        while (item_count - start < 80)
            send_encoded_chunk();
        tx_idle_en = 1'b1;
    endtask

    // sender goes quiet until every result is back, then resumes
    task automatic test_sender_pause();
        int unsigned start;
        for (int r = 0; r < 3; r++) begin
            start = item_count;
            while (item_count - start < 20)
                send_encoded_chunk();
            wait_idle();
        end
    endtask

    task automatic test_full_rate();
        int unsigned start;
        configure(1'b1, 16'd3);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        start = item_count;
        while (item_count - start < 150)
            send_encoded_chunk();
    endtask

    initial begin : main_seq
        enc_mode = 1'b1;
        row_w    = 16'd1;
        clear_decode();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_encoded();
        test_random_raw();
        test_mode_switching();
        test_output_backpressure();
        test_sender_pause();
        test_full_rate();

        in_valid <= 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bad_pixels == 0 && expected_pixels.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
